FILE: rtl/ffha_pkg.sv
package ffha_pkg;

   localparam int MAX_BLOCKS   = 64;
   localparam int IDX_W        = $clog2(MAX_BLOCKS);
   localparam int CNT_W        = $clog2(MAX_BLOCKS + 1);
   localparam int HEADER_BYTES = 32;
   localparam int ARENA_BYTES  = 65536;

   localparam logic [2:0] STATUS_OK         = 3'd0;
   localparam logic [2:0] STATUS_ZERO_SIZE  = 3'd1;
   localparam logic [2:0] STATUS_NO_MEMORY  = 3'd2;
   localparam logic [2:0] STATUS_NOT_FOUND  = 3'd3;
   localparam logic [2:0] STATUS_TABLE_FULL = 3'd4;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   typedef struct packed {
      logic        command;
      logic [16:0] request_bytes;
      logic [15:0] free_address;
   } req_type;

   typedef struct packed {
      logic [15:0] address;
      logic [2:0]  status;
      logic [16:0] granted_bytes;
   } rsp_type;

   typedef struct packed {
      logic [16:0] start;
      logic [16:0] size;
      logic        free;
   } cell_type;

   typedef enum logic [1:0] {
      SHIFT_NONE   = 2'd0,
      SHIFT_INSERT = 2'd1,
      SHIFT_REMOVE = 2'd2
   } shift_type;

   typedef struct packed {
      shift_type        shift;
      logic [IDX_W-1:0] shift_pos;
      cell_type         ins_data;
      logic             wr_en;
      logic [IDX_W-1:0] wr_pos;
      cell_type         wr_data;
   } cell_cmd_type;

endpackage

FILE: rtl/first_fit_heap_allocator_unit.sv
// First-fit heap allocator. One request at a time: start is taken while busy is low.
// busy stays high through the find and execute states after an accept, and a free that
// finds its block also merges with next and previous; no new request is taken till then.
// The result strobe rsp_valid is registered from the execute state and lasts one cycle. The
// receiver cannot stall, so the result must be captured when rsp_valid is high. The
// block table lives in a chain of 64 cells that compare in parallel; a priority select
// picks the first match and an insert or remove shifts the chain by one cell. heap_limit
// may be written only while busy is low.
module first_fit_heap_allocator_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  ffha_pkg::req_type req_item,
   output logic              rsp_valid,
   output ffha_pkg::rsp_type rsp_item,
   input  logic              csr_write_enable,
   input  logic [16:0]       csr_write_data
);
   import ffha_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_FIND  = 5'b00010,
      ST_EXEC  = 5'b00100,
      ST_MNEXT = 5'b01000,
      ST_MPREV = 5'b10000
   } state_type;

   state_type        state_ff, state_in;
   req_type          req_ff, req_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [16:0]      break_ff, break_in;
   logic [16:0]      limit_ff, limit_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             found_ff, found_in;
   logic [16:0]      cur_size_ff, cur_size_in;
   logic [16:0]      cur_start_ff, cur_start_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   cell_type     cells [MAX_BLOCKS];
   logic         fit [MAX_BLOCKS];
   logic         hit [MAX_BLOCKS];
   cell_cmd_type cmd;
   logic [17:0]  rounded;
   logic [16:0]  need;
   logic [IDX_W-1:0] rd_addr;
   cell_type     rd;
   logic [16:0]  left_bytes;
   logic         split;
   logic [17:0]  eff_limit;
   logic [18:0]  grow_end;
   logic         pick_found;
   logic [IDX_W-1:0] pick_idx;

   assign rounded = ({1'b0, req_ff.request_bytes} + 18'd7) & ~18'd7;
   assign need    = rounded[16:0];

   for (genvar k = 0; k < MAX_BLOCKS; k++) begin : g_cell
      cell_type lft, rgt;
      if (k == 0) begin : g_first
         assign lft = '0;
      end else begin : g_mid
         assign lft = cells[k-1];
      end
      if (k == MAX_BLOCKS - 1) begin : g_last
         assign rgt = '0;
      end else begin : g_rest
         assign rgt = cells[k+1];
      end
      ffha_cell u_cell (
         .clock        (clock),
         .index        (IDX_W'(k)),
         .count        (count_ff),
         .cmd          (cmd),
         .left         (lft),
         .right        (rgt),
         .need_bytes   (need),
         .free_address (req_ff.free_address),
         .data         (cells[k]),
         .fit          (fit[k]),
         .hit          (hit[k])
      );
   end

   always_comb begin
      pick_found = 1'b0;
      pick_idx   = '0;
      for (int k = MAX_BLOCKS - 1; k >= 0; k--) begin
         if (req_ff.command == CMD_FREE ? hit[k] : fit[k]) begin
            pick_found = 1'b1;
            pick_idx   = IDX_W'(k);
         end
      end
   end

   always_comb begin
      unique case (state_ff)
         ST_MNEXT: rd_addr = idx_ff + IDX_W'(1);
         ST_MPREV: rd_addr = idx_ff - IDX_W'(1);
         default:  rd_addr = idx_ff;
      endcase
   end
   assign rd = cells[rd_addr];

   assign left_bytes = rd.size - need;
   assign split      = (left_bytes >= 17'(HEADER_BYTES)) && (count_ff < CNT_W'(MAX_BLOCKS));
   assign eff_limit  = ({1'b0, limit_ff} > 18'(ARENA_BYTES)) ? 18'(ARENA_BYTES)
                                                             : {1'b0, limit_ff};
   assign grow_end   = {2'b00, break_ff} + 19'(HEADER_BYTES) + {1'b0, rounded};

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      count_in     = count_ff;
      break_in     = break_ff;
      limit_in     = csr_write_enable ? csr_write_data : limit_ff;
      idx_in       = idx_ff;
      found_in     = found_ff;
      cur_size_in  = cur_size_ff;
      cur_start_in = cur_start_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      cmd          = '0;
      cmd.shift    = SHIFT_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in   = req_item;
               state_in = ST_FIND;
            end
         end
         ST_FIND: begin
            idx_in   = pick_idx;
            found_in = pick_found && !(req_ff.command == CMD_ALLOC && rounded[17]);
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            rsp_valid_in = 1'b1;
            rsp_in       = '0;
            state_in     = ST_IDLE;
            if (req_ff.command == CMD_ALLOC) begin
               if (req_ff.request_bytes == '0) begin
                  rsp_in.status = STATUS_ZERO_SIZE;
               end else if (found_ff) begin
                  cmd.wr_en        = 1'b1;
                  cmd.wr_pos       = idx_ff;
                  cmd.wr_data      = '{start: rd.start, size: split ? need : rd.size, free: 1'b0};
                  if (split) begin
                     cmd.shift     = SHIFT_INSERT;
                     cmd.shift_pos = idx_ff + IDX_W'(1);
                     cmd.ins_data  = '{start: rd.start + 17'(HEADER_BYTES) + need,
                                       size: left_bytes - 17'(HEADER_BYTES), free: 1'b1};
                     count_in      = count_ff + CNT_W'(1);
                  end
                  rsp_in.address       = 16'(rd.start + 17'(HEADER_BYTES));
                  rsp_in.granted_bytes = split ? need : rd.size;
               end else if (grow_end > {1'b0, eff_limit}) begin
                  rsp_in.status = STATUS_NO_MEMORY;
               end else if (count_ff >= CNT_W'(MAX_BLOCKS)) begin
                  rsp_in.status = STATUS_TABLE_FULL;
               end else begin
                  cmd.shift            = SHIFT_INSERT;
                  cmd.shift_pos        = count_ff[IDX_W-1:0];
                  cmd.ins_data         = '{start: break_ff, size: need, free: 1'b0};
                  count_in             = count_ff + CNT_W'(1);
                  break_in             = grow_end[16:0];
                  rsp_in.address       = 16'(break_ff + 17'(HEADER_BYTES));
                  rsp_in.granted_bytes = need;
               end
            end else begin
               if (!found_ff) begin
                  rsp_in.status = STATUS_NOT_FOUND;
               end else begin
                  cmd.wr_en            = 1'b1;
                  cmd.wr_pos           = idx_ff;
                  cmd.wr_data          = '{start: rd.start, size: rd.size, free: 1'b1};
                  cur_size_in          = rd.size;
                  cur_start_in         = rd.start;
                  rsp_in.granted_bytes = rd.size;
                  state_in             = ST_MNEXT;
               end
            end
         end
         ST_MNEXT: begin
            state_in = ST_MPREV;
            if (({1'b0, idx_ff} + CNT_W'(1)) < count_ff && rd.free) begin
               cur_size_in   = cur_size_ff + rd.size + 17'(HEADER_BYTES);
               cmd.wr_en     = 1'b1;
               cmd.wr_pos    = idx_ff;
               cmd.wr_data   = '{start: cur_start_ff, size: cur_size_in, free: 1'b1};
               cmd.shift     = SHIFT_REMOVE;
               cmd.shift_pos = idx_ff + IDX_W'(1);
               count_in      = count_ff - CNT_W'(1);
            end
         end
         ST_MPREV: begin
            state_in = ST_IDLE;
            if (idx_ff != '0 && rd.free) begin
               cmd.wr_en     = 1'b1;
               cmd.wr_pos    = idx_ff - IDX_W'(1);
               cmd.wr_data   = '{start: rd.start,
                                 size: rd.size + cur_size_ff + 17'(HEADER_BYTES), free: 1'b1};
               cmd.shift     = SHIFT_REMOVE;
               cmd.shift_pos = idx_ff;
               count_in      = count_ff - CNT_W'(1);
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         break_ff     <= '0;
         limit_ff     <= 17'(ARENA_BYTES);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         break_ff     <= break_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff       <= req_in;
      idx_ff       <= idx_in;
      found_ff     <= found_in;
      cur_size_ff  <= cur_size_in;
      cur_start_ff <= cur_start_in;
      rsp_ff       <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("accepted request did not raise busy");
   a_rsp_after_exec: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == ST_EXEC)) else $error("result without execute step");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_BLOCKS)) else $error("block count overflow");
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.status != STATUS_OK |-> rsp_item.granted_bytes == '0)
      else $error("failed request reports bytes");

endmodule

FILE: rtl/ffha_cell.sv
module ffha_cell (
   input  logic                      clock,
   input  logic [ffha_pkg::IDX_W-1:0] index,
   input  logic [ffha_pkg::CNT_W-1:0] count,
   input  ffha_pkg::cell_cmd_type    cmd,
   input  ffha_pkg::cell_type        left,
   input  ffha_pkg::cell_type        right,
   input  logic [16:0]               need_bytes,
   input  logic [15:0]               free_address,
   output ffha_pkg::cell_type        data,
   output logic                      fit,
   output logic                      hit
);
   import ffha_pkg::*;

   cell_type data_ff;
   cell_type data_in;
   logic     valid;
   logic [17:0] payload;

   always_comb begin
      data_in = data_ff;
      case (cmd.shift)
         SHIFT_INSERT: begin
            if (index > cmd.shift_pos) data_in = left;
            else if (index == cmd.shift_pos) data_in = cmd.ins_data;
         end
         SHIFT_REMOVE: begin
            if (index >= cmd.shift_pos) data_in = right;
         end
         default: ;
      endcase
      if (cmd.wr_en && index == cmd.wr_pos) data_in = cmd.wr_data;
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign valid   = {1'b0, index} < count;
   assign payload = {1'b0, data_ff.start} + 18'(HEADER_BYTES);
   assign fit     = valid && data_ff.free && (data_ff.size >= need_bytes);
   assign hit     = valid && (payload == {2'b00, free_address});
   assign data    = data_ff;

endmodule
